FILE: rtl/kfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfb_pkg
// Types, constants and fixed-point helpers shared by the Kalman filter bank.
// ----------------------------------------------------------------------------
package kfb_pkg;

	localparam logic [16:0] Q_ONE = 17'h10000;

	// restoring divider: 48 quotient bits, two per stage
	localparam int DIV_W      = 48;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;

	// register stages from the memory read register to tvar
	localparam int PRED_STAGES = 8;
	// register stages after the divider up to the state write-back
	localparam int UPD_WR_STAGES = 2;
	// edges from acceptance to the state write
	localparam int WR_LAT = 1 + PRED_STAGES + DIV_STAGES + 1 + UPD_WR_STAGES;

	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef logic signed [51:0] wide_t;

	typedef struct packed {
		logic              action;
		logic [7:0]        filter_index;
		logic signed [31:0] target;
		logic signed [31:0] signal_now;
		logic signed [31:0] signal_next;
		logic              signal_missing;
		logic [20:0]       inv_lambda;
		logic [16:0]       kappa;
		logic signed [31:0] init_slope;
		logic [30:0]       init_var_intercept;
		logic [30:0]       init_var_slope;
		logic [30:0]       init_obs_var;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] forecast_mean;
		logic [30:0]       forecast_variance;
		logic              forecast_valid;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] coef_intercept;
		logic signed [31:0] coef_slope;
		logic signed [31:0] cov_intercept;
		logic signed [31:0] cov_cross;
		logic signed [31:0] cov_slope;
		logic signed [31:0] obs_variance;
		logic [20:0]       inv_lambda;
		logic [16:0]       kappa;
	} state_t;

	typedef struct packed {
		logic       en;
		logic [7:0] idx;
		state_t     data;
	} mem_wr_t;

	typedef struct packed {
		logic       wr;    // transaction writes the filter state
		logic       upd;   // real update, result is valid
		logic       load;
		logic [7:0] idx;
	} ctl_t;

	// one transaction as it moves down the pipeline
	typedef struct packed {
		ctl_t               ctl;
		state_t             st;
		logic signed [31:0] y;
		logic signed [31:0] s;
		logic signed [31:0] sn;
		wide_t              pa;
		wide_t              pb;
		wide_t              pc;
		wide_t              pd;
		wide_t              pe;
		logic signed [31:0] r00;
		logic signed [31:0] r01;
		logic signed [31:0] r11;
		logic signed [31:0] pred;
		logic signed [31:0] e;
		logic signed [31:0] e2;
		logic signed [31:0] v0;
		logic signed [31:0] v1;
		logic signed [31:0] q;
		logic signed [31:0] h;
		logic signed [31:0] tvar;
		logic signed [31:0] k0;
		logic signed [31:0] k1;
		logic signed [31:0] b0n;
		logic signed [31:0] b1n;
		logic signed [31:0] p00;
		logic signed [31:0] p01;
		logic signed [31:0] p11;
		logic signed [31:0] mean;
		logic signed [31:0] u0;
		logic signed [31:0] u1;
		logic signed [31:0] qq;
		logic signed [31:0] fvar;
	} rec_t;

	typedef struct packed {
		logic [31:0]      rem;
		logic [DIV_W-1:0] num;   // dividend bits out at the top, quotient in at the bottom
	} div_lane_t;

	// Q16.16 product, rounded half up
	function automatic wide_t mulq(logic signed [32:0] a, logic signed [32:0] b);
		logic signed [65:0] p;
		logic signed [65:0] r;
		p = a * b;
		r = (p + 66'sd32768) >>> 16;
		return r[51:0];
	endfunction

	function automatic logic signed [31:0] sat32(wide_t v);
		if (v > wide_t'(S32_MAX))
			return S32_MAX;
		else if (v < wide_t'(S32_MIN))
			return S32_MIN;
		return v[31:0];
	endfunction

	function automatic div_lane_t div_step(div_lane_t x, logic [30:0] d);
		div_lane_t   r;
		logic [31:0] t;
		logic        ge;
		r = x;
		for (int i = 0; i < DIV_STEP; i++) begin
			t     = {r.rem[30:0], r.num[DIV_W-1]};
			ge    = (t >= {1'b0, d});
			r.num = {r.num[DIV_W-2:0], ge};
			r.rem = ge ? (t - {1'b0, d}) : t;
		end
		return r;
	endfunction

endpackage

FILE: rtl/kfb_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfb_state_mem
// Per-filter state store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kfb_state_mem #(
	parameter int NUM_FILTERS = 256
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [7:0]       rd_idx,
	output kfb_pkg::state_t  rd_data,
	input  kfb_pkg::mem_wr_t wr
);
	import kfb_pkg::*;

	localparam int ADDR_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

	state_t mem [NUM_FILTERS];

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[ADDR_W'(wr.idx)] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[ADDR_W'(rd_idx)];
	end

endmodule

FILE: rtl/kfb_predict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfb_predict
// Covariance inflation, prediction error, observation variance average and
// innovation variance, eight register stages.
// ----------------------------------------------------------------------------
module kfb_predict (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_in,
	input  kfb_pkg::ctl_t     ctl_in,
	input  kfb_pkg::in_item_t item_in,
	input  kfb_pkg::state_t   rd_data,
	output logic              vld_out,
	output kfb_pkg::rec_t     rec_out
);
	import kfb_pkg::*;

	state_t ld;
	state_t st;
	rec_t   n2, n3, n4, n5, n6, n7, n8, n9;
	rec_t   rec_s2, rec_s3, rec_s4, rec_s5, rec_s6, rec_s7, rec_s8, rec_s9;
	logic   vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_comb begin
		ld.coef_intercept = '0;
		ld.coef_slope     = item_in.init_slope;
		ld.cov_intercept  = {1'b0, item_in.init_var_intercept};
		ld.cov_cross      = '0;
		ld.cov_slope      = {1'b0, item_in.init_var_slope};
		ld.obs_variance   = {1'b0, item_in.init_obs_var};
		ld.inv_lambda     = item_in.inv_lambda;
		ld.kappa          = (item_in.kappa > Q_ONE) ? Q_ONE : item_in.kappa;
		st = ctl_in.load ? ld : rd_data;

		// inflate covariance, slope term of the prediction, decayed obs variance
		n2     = '0;
		n2.ctl = ctl_in;
		n2.st  = st;
		n2.y   = item_in.target;
		n2.s   = item_in.signal_now;
		n2.sn  = item_in.signal_next;
		n2.pa  = mulq(33'(st.cov_intercept), 33'(st.inv_lambda));
		n2.pb  = mulq(33'(st.cov_cross), 33'(st.inv_lambda));
		n2.pc  = mulq(33'(st.cov_slope), 33'(st.inv_lambda));
		n2.pd  = mulq(33'(st.coef_slope), 33'(item_in.signal_now));
		n2.pe  = mulq(33'(st.kappa), 33'(st.obs_variance));

		n3      = rec_s2;
		n3.r00  = sat32(rec_s2.pa);
		n3.r01  = sat32(rec_s2.pb);
		n3.r11  = sat32(rec_s2.pc);
		n3.pred = sat32(wide_t'(rec_s2.st.coef_intercept) + rec_s2.pd);

		n4    = rec_s3;
		n4.e  = sat32(wide_t'(rec_s3.y) - wide_t'(rec_s3.pred));
		n4.pa = mulq(33'(rec_s3.r01), 33'(rec_s3.s));
		n4.pb = mulq(33'(rec_s3.r11), 33'(rec_s3.s));

		n5    = rec_s4;
		n5.pc = mulq(33'(rec_s4.e), 33'(rec_s4.e));
		n5.v0 = sat32(wide_t'(rec_s4.r00) + rec_s4.pa);
		n5.v1 = sat32(wide_t'(rec_s4.r01) + rec_s4.pb);

		n6    = rec_s5;
		n6.e2 = sat32(rec_s5.pc);
		n6.pa = mulq(33'(rec_s5.v1), 33'(rec_s5.s));

		n7    = rec_s6;
		n7.pb = mulq(33'(17'(Q_ONE - rec_s6.st.kappa)), 33'(rec_s6.e2));
		n7.q  = sat32(wide_t'(rec_s6.v0) + rec_s6.pa);

		n8   = rec_s7;
		n8.h = sat32(rec_s7.pe + rec_s7.pb);

		n9      = rec_s8;
		n9.tvar = sat32(wide_t'(rec_s8.h) + wide_t'(rec_s8.q));
	end

	always_ff @(posedge clk) begin
		rec_s2 <= n2;
		rec_s3 <= n3;
		rec_s4 <= n4;
		rec_s5 <= n5;
		rec_s6 <= n6;
		rec_s7 <= n7;
		rec_s8 <= n8;
		rec_s9 <= n9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s2 <= vld_in;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign vld_out = vld_s9;
	assign rec_out = rec_s9;

endmodule

FILE: rtl/kfb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfb_div
// Pipelined restoring divider pair for the two Kalman gains,
// (v * 2^16) / tvar truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module kfb_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  kfb_pkg::rec_t rec_in,
	output logic          vld_out,
	output kfb_pkg::rec_t rec_out
);
	import kfb_pkg::*;

	div_lane_t init0, init1;
	logic [31:0] mag0, mag1;

	div_lane_t lane0_s [DIV_STAGES];
	div_lane_t lane1_s [DIV_STAGES];
	rec_t      rec_s   [DIV_STAGES];
	logic      vld_s   [DIV_STAGES];

	rec_t rec_k;
	logic vld_k;
	rec_t nk;

	function automatic logic signed [31:0] gain_sat(logic [DIV_W-1:0] q, logic neg,
		logic pos);
		if (!pos)
			return '0;
		else if (neg)
			return (q > DIV_W'(33'h080000000)) ? S32_MIN : 32'(32'd0 - q[31:0]);
		return (q > DIV_W'(32'h7fffffff)) ? S32_MAX : q[31:0];
	endfunction

	always_comb begin
		mag0 = rec_in.v0[31] ? 32'(33'd0 - 33'(rec_in.v0)) : rec_in.v0;
		mag1 = rec_in.v1[31] ? 32'(33'd0 - 33'(rec_in.v1)) : rec_in.v1;
		init0.rem = '0;
		init0.num = {mag0, 16'd0};
		init1.rem = '0;
		init1.num = {mag1, 16'd0};
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		div_lane_t src0, src1;
		rec_t      srec;
		logic      svld;

		if (g == 0) begin : g_first
			assign src0 = init0;
			assign src1 = init1;
			assign srec = rec_in;
			assign svld = vld_in;
		end else begin : g_rest
			assign src0 = lane0_s[g-1];
			assign src1 = lane1_s[g-1];
			assign srec = rec_s[g-1];
			assign svld = vld_s[g-1];
		end

		always_ff @(posedge clk) begin
			lane0_s[g] <= div_step(src0, srec.tvar[30:0]);
			lane1_s[g] <= div_step(src1, srec.tvar[30:0]);
			rec_s[g]   <= srec;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g] <= 1'b0;
			else
				vld_s[g] <= svld;
		end
	end

	always_comb begin
		nk    = rec_s[DIV_STAGES-1];
		nk.k0 = gain_sat(lane0_s[DIV_STAGES-1].num, nk.v0[31], nk.tvar > 0);
		nk.k1 = gain_sat(lane1_s[DIV_STAGES-1].num, nk.v1[31], nk.tvar > 0);
	end

	always_ff @(posedge clk) begin
		rec_k <= nk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_k <= 1'b0;
		else
			vld_k <= vld_s[DIV_STAGES-1];
	end

	assign vld_out = vld_k;
	assign rec_out = rec_k;

endmodule

FILE: rtl/kfb_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfb_update
// Gain applied to coefficients and covariance, state write-back, and the
// forecast mean and variance for the next signal value.
// ----------------------------------------------------------------------------
module kfb_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  kfb_pkg::rec_t      rec_in,
	output kfb_pkg::mem_wr_t   wr,
	output logic               done,
	output kfb_pkg::out_item_t result
);
	import kfb_pkg::*;

	rec_t m1, m2, m3, m4, m5, m6, m7;
	rec_t rec_s1, rec_s2, rec_s3, rec_s4, rec_s5, rec_s6, rec_s7;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, done_s8;
	out_item_t res_s8, nres;
	logic signed [31:0] fvar;

	always_comb begin
		m1    = rec_in;
		m1.pa = mulq(33'(rec_in.k0), 33'(rec_in.e));
		m1.pb = mulq(33'(rec_in.k1), 33'(rec_in.e));
		m1.pc = mulq(33'(rec_in.k0), 33'(rec_in.v0));
		m1.pd = mulq(33'(rec_in.k0), 33'(rec_in.v1));
		m1.pe = mulq(33'(rec_in.k1), 33'(rec_in.v1));

		m2     = rec_s1;
		m2.b0n = sat32(wide_t'(rec_s1.st.coef_intercept) + rec_s1.pa);
		m2.b1n = sat32(wide_t'(rec_s1.st.coef_slope) + rec_s1.pb);
		m2.p00 = sat32(wide_t'(rec_s1.r00) - rec_s1.pc);
		m2.p01 = sat32(wide_t'(rec_s1.r01) - rec_s1.pd);
		m2.p11 = sat32(wide_t'(rec_s1.r11) - rec_s1.pe);

		m3    = rec_s2;
		m3.pa = mulq(33'(rec_s2.b1n), 33'(rec_s2.sn));
		m3.pb = mulq(33'(rec_s2.p01), 33'(rec_s2.sn));
		m3.pc = mulq(33'(rec_s2.p11), 33'(rec_s2.sn));

		m4      = rec_s3;
		m4.mean = sat32(wide_t'(rec_s3.b0n) + rec_s3.pa);
		m4.u0   = sat32(wide_t'(rec_s3.p00) + rec_s3.pb);
		m4.u1   = sat32(wide_t'(rec_s3.p01) + rec_s3.pc);

		m5    = rec_s4;
		m5.pa = mulq(33'(rec_s4.u1), 33'(rec_s4.sn));

		m6    = rec_s5;
		m6.qq = sat32(wide_t'(rec_s5.u0) + rec_s5.pa);

		m7    = rec_s6;
		m7.pa = mulq(33'(rec_s6.qq), 33'(rec_s6.st.inv_lambda));

		fvar = sat32(wide_t'(rec_s7.h) + wide_t'(sat32(rec_s7.pa)));
		nres = '0;
		if (rec_s7.ctl.upd) begin
			nres.forecast_mean     = rec_s7.mean;
			nres.forecast_variance = fvar[31] ? '0 : fvar[30:0];
			nres.forecast_valid    = 1'b1;
		end
	end

	// state write-back
	always_comb begin
		wr.en  = vld_s2 & rec_s2.ctl.wr;
		wr.idx = rec_s2.ctl.idx;
		if (rec_s2.ctl.load) begin
			wr.data = rec_s2.st;
		end else begin
			wr.data.coef_intercept = rec_s2.b0n;
			wr.data.coef_slope     = rec_s2.b1n;
			wr.data.cov_intercept  = rec_s2.p00;
			wr.data.cov_cross      = rec_s2.p01;
			wr.data.cov_slope      = rec_s2.p11;
			wr.data.obs_variance   = rec_s2.h;
			wr.data.inv_lambda     = rec_s2.st.inv_lambda;
			wr.data.kappa          = rec_s2.st.kappa;
		end
	end

	always_ff @(posedge clk) begin
		rec_s1 <= m1;
		rec_s2 <= m2;
		rec_s3 <= m3;
		rec_s4 <= m4;
		rec_s5 <= m5;
		rec_s6 <= m6;
		rec_s7 <= m7;
		res_s8 <= nres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			done_s8 <= 1'b0;
		end else begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			done_s8 <= vld_s7;
		end
	end

	assign done   = done_s8;
	assign result = res_s8;

endmodule

FILE: rtl/tvc_kalman_filter_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvc_kalman_filter_bank
// Bank of two-coefficient forgetting-factor regression Kalman filters.
// ----------------------------------------------------------------------------
// A transaction is taken on any clock where start is high and busy is low, one
// per cycle while busy stays low. Each transaction gives exactly one result, on
// result with done high for a single cycle, in the order taken; the result
// cannot be held off, so it must be captured when done is high. busy is high
// while the filter named on filter_index still has a state-writing transaction
// in the pipe before its state write-back (the per-filter state sits in one
// memory with a single write port at the end of the gain update), so a new
// transaction on the same filter waits until that write-back is done.
// The gain division uses a 24-stage restoring divider, two quotient bits a
// stage. There is no clearing pass; a filter must be loaded before update.
// ----------------------------------------------------------------------------
module tvc_kalman_filter_bank #(
	parameter int NUM_FILTERS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  kfb_pkg::in_item_t  item,
	output logic               done,
	output kfb_pkg::out_item_t result
);
	import kfb_pkg::*;

	logic     accept;
	logic     in_range;
	ctl_t     ctl_in;
	ctl_t     ctl_s1;
	in_item_t item_s1;
	logic     vld_s1;
	state_t   rd_data;
	mem_wr_t  wr;

	logic     pre_vld, div_vld;
	rec_t     pre_rec, div_rec;

	// write tracking: which filters still have a state write outstanding
	logic       sb_wr_s  [WR_LAT];
	logic [7:0] sb_idx_s [WR_LAT];

	always_comb begin
		busy = 1'b0;
		for (int j = 0; j < WR_LAT; j++) begin
			if (sb_wr_s[j] && (sb_idx_s[j] == item.filter_index))
				busy = 1'b1;
		end
	end

	assign accept   = start & ~busy;
	assign in_range = (int'(item.filter_index) < NUM_FILTERS);

	always_comb begin
		ctl_in.load = in_range & ~item.action;
		ctl_in.upd  = in_range & item.action & ~item.signal_missing;
		ctl_in.wr   = ctl_in.load | ctl_in.upd;
		ctl_in.idx  = item.filter_index;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1  <= ctl_in;
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int j = 0; j < WR_LAT; j++)
				sb_wr_s[j] <= 1'b0;
		end else begin
			vld_s1     <= accept;
			sb_wr_s[0] <= accept & ctl_in.wr;
			for (int j = 1; j < WR_LAT; j++)
				sb_wr_s[j] <= sb_wr_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		sb_idx_s[0] <= item.filter_index;
		for (int j = 1; j < WR_LAT; j++)
			sb_idx_s[j] <= sb_idx_s[j-1];
	end

	kfb_state_mem #(
		.NUM_FILTERS (NUM_FILTERS)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_idx  (item.filter_index),
		.rd_data (rd_data),
		.wr      (wr)
	);

	kfb_predict u_predict (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s1),
		.ctl_in  (ctl_s1),
		.item_in (item_s1),
		.rd_data (rd_data),
		.vld_out (pre_vld),
		.rec_out (pre_rec)
	);

	kfb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (pre_vld),
		.rec_in  (pre_rec),
		.vld_out (div_vld),
		.rec_out (div_rec)
	);

	kfb_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (div_vld),
		.rec_in (div_rec),
		.wr     (wr),
		.done   (done),
		.result (result)
	);

endmodule
